>>> src/gzhp_pkg.sv
// package: item types, phase codes, kinds and header constants for the gzip header parser
`timescale 1ns / 1ps

package gzhp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] item_kind;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

    localparam logic [2:0] PH_FIXED   = 3'd0;
    localparam logic [2:0] PH_OS      = 3'd1;
    localparam logic [2:0] PH_XLEN0   = 3'd2;
    localparam logic [2:0] PH_XLEN1   = 3'd3;
    localparam logic [2:0] PH_XDATA   = 3'd4;
    localparam logic [2:0] PH_NAME    = 3'd5;
    localparam logic [2:0] PH_COMMENT = 3'd6;
    localparam logic [2:0] PH_CRC     = 3'd7;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [7:0] MAGIC0       = 8'h1f;
    localparam logic [7:0] MAGIC1       = 8'h8b;
    localparam logic [7:0] METHOD_DEFL  = 8'h08;
    localparam logic [7:0] FLG_RESERVED = 8'he0;

    localparam int FLG_HCRC_BIT    = 1;
    localparam int FLG_EXTRA_BIT   = 2;
    localparam int FLG_NAME_BIT    = 3;
    localparam int FLG_COMMENT_BIT = 4;

    localparam logic [15:0] FIXED_LEN = 16'd4;
    localparam logic [15:0] OS_LEN    = 16'd6;
    localparam logic [15:0] CRC_LEN   = 16'd2;

endpackage

>>> src/gzhp_in_reg.sv
// input register stage for incoming stream bytes
`timescale 1ns / 1ps

module gzhp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  gzhp_pkg::in_item_t byte_item,
    input  logic              advance,
    output logic              byte_stall,
    output gzhp_pkg::stage_t  s1
);
    import gzhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign byte_stall = valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= byte_item;
        end
    end

    assign s1.valid = valid_reg;
    assign s1.item  = item_reg;

endmodule

>>> src/gzhp_core.sv
// header parse state and per-byte classification logic
`timescale 1ns / 1ps

module gzhp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  gzhp_pkg::in_item_t item,
    input  logic               advance,
    output logic [1:0]         item_kind
);
    import gzhp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] xlen_reg, xlen_next;
    logic [7:0]  flags_reg, flags_next;
    logic        done_reg, done_next;
    logic        err_reg, err_next;

    logic [2:0]  ph_c;
    logic [15:0] cnt_c;
    logic [15:0] xlen_c;
    logic [7:0]  flg_c;
    logic        done_c;
    logic        err_c;

    logic [7:0]  b;
    logic [15:0] cnt_inc;
    logic [15:0] crc_base;
    logic [15:0] crc_inc;
    logic        mismatch;
    logic        go_name;
    logic        at_name;
    logic        at_comment;

    assign b = item.data_byte;

    // new stream restarts from reset values
    always_comb
    begin
        if (item.start_stream)
        begin
            ph_c   = PH_FIXED;
            cnt_c  = '0;
            xlen_c = '0;
            flg_c  = '0;
            done_c = 1'b0;
            err_c  = 1'b0;
        end
        else
        begin
            ph_c   = phase_reg;
            cnt_c  = count_reg;
            xlen_c = xlen_reg;
            flg_c  = flags_reg;
            done_c = done_reg;
            err_c  = err_reg;
        end
    end

    assign cnt_inc    = cnt_c + 16'd1;
    assign mismatch   = (cnt_c == 16'd0 && b != MAGIC0) ||
                        (cnt_c == 16'd1 && b != MAGIC1) ||
                        (cnt_c == 16'd2 && b != METHOD_DEFL);
    assign go_name    = (ph_c == PH_XLEN0 && !flg_c[FLG_EXTRA_BIT]) ||
                        (ph_c == PH_XDATA && cnt_c == xlen_c);
    assign at_name    = (ph_c == PH_NAME) || go_name;
    assign at_comment = (ph_c == PH_COMMENT) || (at_name && !flg_c[FLG_NAME_BIT]);
    assign crc_base   = at_comment ? 16'd0 : cnt_c;
    assign crc_inc    = crc_base + 16'd1;

    always_comb
    begin
        phase_next = ph_c;
        count_next = cnt_c;
        xlen_next  = xlen_c;
        flags_next = flg_c;
        done_next  = done_c;
        err_next   = err_c;
        item_kind  = KIND_HEADER;
        if (err_c)
        begin
            item_kind = KIND_ERROR;
        end
        else if (done_c)
        begin
            item_kind = KIND_PAYLOAD;
        end
        else
        begin
            case (ph_c)
                PH_FIXED:
                begin
                    if (mismatch)
                    begin
                        err_next  = 1'b1;
                        item_kind = KIND_ERROR;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc >= FIXED_LEN)
                        begin
                            flags_next = b;
                            if ((b & FLG_RESERVED) != 8'd0)
                            begin
                                err_next  = 1'b1;
                                item_kind = KIND_ERROR;
                            end
                            else
                            begin
                                phase_next = PH_OS;
                                count_next = '0;
                            end
                        end
                    end
                end
                PH_OS:
                begin
                    count_next = cnt_inc;
                    if (cnt_inc >= OS_LEN)
                    begin
                        phase_next = PH_XLEN0;
                    end
                end
                PH_XLEN1:
                begin
                    xlen_next  = {b, xlen_c[7:0]};
                    count_next = '0;
                    phase_next = PH_XDATA;
                end
                default:
                begin
                    if (ph_c == PH_XLEN0 && flg_c[FLG_EXTRA_BIT])
                    begin
                        xlen_next  = {8'd0, b};
                        phase_next = PH_XLEN1;
                    end
                    else if (ph_c == PH_XDATA && cnt_c != xlen_c)
                    begin
                        count_next = cnt_inc;
                    end
                    else if (at_name && flg_c[FLG_NAME_BIT])
                    begin
                        phase_next = (b == 8'd0) ? PH_COMMENT : PH_NAME;
                    end
                    else if (at_comment && flg_c[FLG_COMMENT_BIT])
                    begin
                        phase_next = PH_COMMENT;
                        if (b == 8'd0)
                        begin
                            phase_next = PH_CRC;
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_CRC;
                        count_next = crc_base;
                        if (flg_c[FLG_HCRC_BIT])
                        begin
                            count_next = crc_inc;
                            if (crc_inc >= CRC_LEN)
                            begin
                                done_next = 1'b1;
                            end
                        end
                        else
                        begin
                            done_next = 1'b1;
                            item_kind = KIND_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIXED;
            count_reg <= '0;
            xlen_reg  <= '0;
            flags_reg <= '0;
            done_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            xlen_reg  <= xlen_next;
            flags_reg <= flags_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> src/gzip_header_parser_top.sv
// top level of the gzip member header parser
//
//  channel   dir  handshake                   item
//  byte      in   byte_valid / byte_stall     byte_item   (data_byte, start_stream)
//  result    out  result_valid / result_stall result_item (out_byte, item_kind)
//
// one byte per clock sustained while result_stall is low; a byte passes the input register, then the result register
// the rate is set by the single parse step between the input and result registers
// rst_n clears the parse state and both valid flags asynchronously
// byte_stall rises only while both registers are full and result_stall is high
`timescale 1ns / 1ps

module gzip_header_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  gzhp_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output gzhp_pkg::out_item_t result_item
);
    import gzhp_pkg::*;

    stage_t    s1;
    logic      advance;
    logic [1:0] kind;
    logic      result_valid_reg, result_valid_next;
    out_item_t result_item_reg;

    assign advance = s1.valid && (!result_valid_reg || !result_stall);

    gzhp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_item  (byte_item),
        .advance    (advance),
        .byte_stall (byte_stall),
        .s1         (s1)
    );

    gzhp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (s1.item),
        .advance   (advance),
        .item_kind (kind)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_item_reg.out_byte  <= s1.item.data_byte;
            result_item_reg.item_kind <= kind;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

>>> src/gzhp_checker.sv
// port-level checks for the gzip header parser, bound to the top level
`timescale 1ns / 1ps

module gzhp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_stall,
    input gzhp_pkg::in_item_t  byte_item,
    input logic                result_valid,
    input logic                result_stall,
    input gzhp_pkg::out_item_t result_item
);
    import gzhp_pkg::*;

    // a stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result item changed");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_item.item_kind != KIND_UNUSED)
        else $error("unused item kind");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid && result_stall)
        else $error("input stalled with free output");

    // bad first magic byte of a new stream is an error once it has passed the input and result registers
    a_bad_magic: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && byte_item.start_stream &&
         byte_item.data_byte != MAGIC0) ##1 (!result_valid || !result_stall)
        |=> result_valid && result_item.item_kind == KIND_ERROR &&
            result_item.out_byte == $past(byte_item.data_byte, 2))
        else $error("bad magic byte not flagged");

endmodule

bind gzip_header_parser_top gzhp_checker u_gzhp_checker (.*);
